FILE: hdl/wfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wfba_pkg;

  localparam int CFG_W       = 5;
  localparam int IN_IDX_W    = 4;
  localparam int IN_SIZE_W   = 16;
  localparam int OUT_BLOCK_W = 4;
  localparam int OUT_SIZE_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } wfba_state_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/wfba_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wfba_in_if import wfba_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [IN_IDX_W-1:0]  block_index;
  logic [IN_SIZE_W-1:0] size;

  modport source (output valid, output mode, output block_index, output size, input ready);
  modport sink   (input valid, input mode, input block_index, input size, output ready);
endinterface

interface wfba_out_if import wfba_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [OUT_BLOCK_W-1:0] chosen_block;
  logic [OUT_SIZE_W-1:0]  remaining_size;

  modport source (output valid, output granted, output chosen_block, output remaining_size,
                  input ready);
  modport sink   (input valid, input granted, input chosen_block, input remaining_size,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/wfba_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module wfba_cell import wfba_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] shift_in,
  input  logic [W-1:0] wr_data,
  output logic [W-1:0] val
);

  logic [W-1:0] val_r;

  // direct write wins over rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctrl.wr) begin
      val_r <= wr_data;
    end else if (ctrl.shift) begin
      val_r <= shift_in;
    end
  end

  assign val = val_r;

endmodule
`default_nettype wire

FILE: hdl/worst_fit_block_allocator_top.sv
// A request scans the ring of cells as it rotates once past the compare head, and no
// new item is taken until its result has moved to the output register; loads are taken
// every cycle while idle.
// A finished result sits in an output register, so the next item may enter before it is taken.
// Reset (rst_n, synchronous, active low) clears every block size to zero and sets
// the block-count register cfg_r to 16.
`timescale 1ns / 1ps
`default_nettype none
module worst_fit_block_allocator_top import wfba_pkg::*; #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  wfba_in_if.sink          in_ch,
  wfba_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  wfba_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_r;
  logic [CW-1:0]         cnt_r;
  logic [SIZE_WIDTH-1:0] req_r;
  logic                  found_r;
  logic [SIZE_WIDTH-1:0] best_val_r;
  logic [IW-1:0]         best_idx_r;

  logic                   out_valid_r;
  logic                   out_granted_r;
  logic [OUT_BLOCK_W-1:0] out_block_r;
  logic [OUT_SIZE_W-1:0]  out_rem_r;

  logic                  in_ready;
  logic                  in_fire;
  logic                  shift;
  logic                  out_free;
  logic                  finish_go;
  logic                  in_limit;
  logic                  last;
  logic                  cand;
  logic [SIZE_WIDTH-1:0] head;
  logic [SIZE_WIDTH-1:0] rem;
  logic [SIZE_WIDTH-1:0] size_w;

  logic [SIZE_WIDTH+IN_SIZE_W-1:0]  size_ext;
  logic [SIZE_WIDTH+OUT_SIZE_W-1:0] rem_ext;
  logic [IW+OUT_BLOCK_W-1:0]        idx_ext;

  logic [SIZE_WIDTH-1:0] cell_val [NUM_BLOCKS];

  assign size_ext = {{SIZE_WIDTH{1'b0}}, in_ch.size};
  assign size_w   = size_ext[SIZE_WIDTH-1:0];
  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign finish_go = (state_r == ST_FINISH) && out_free;

  // cell 0 is the compare head; after cnt_r rotations it holds entry cnt_r
  assign head     = cell_val[0];
  assign in_limit = LW'(cnt_r) < LW'(cfg_r);
  assign last     = cnt_r == CW'(NUM_BLOCKS - 1);
  assign cand     = in_limit && (head >= req_r) && (!found_r || head > best_val_r);
  assign rem      = best_val_r - req_r;
  assign rem_ext  = {{OUT_SIZE_W{1'b0}}, rem};
  assign idx_ext  = {{OUT_BLOCK_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    shift     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && in_ch.mode == MODE_REQ) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (in_fire && in_ch.mode == MODE_REQ) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + CW'(1);
      if (cand) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.mode == MODE_REQ) begin
      req_r      <= size_w;
      best_val_r <= '0;
      best_idx_r <= '0;
    end else if (state_r == ST_SCAN && cand) begin
      best_val_r <= head;
      best_idx_r <= cnt_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_granted_r <= found_r;
      out_block_r   <= found_r ? idx_ext[OUT_BLOCK_W-1:0] : '0;
      out_rem_r     <= found_r ? rem_ext[OUT_SIZE_W-1:0] : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted        = out_granted_r;
  assign out_ch.chosen_block   = out_block_r;
  assign out_ch.remaining_size = out_rem_r;

  genvar i;
  generate
    for (i = 0; i < NUM_BLOCKS; i++) begin : g_cell
      localparam int NXT = (i + 1) % NUM_BLOCKS;
      cell_ctrl_t            ctrl;
      logic                  load_hit;
      logic                  charge_hit;
      logic [SIZE_WIDTH-1:0] wr_data;

      assign load_hit   = in_fire && in_ch.mode == MODE_LOAD &&
                          32'(in_ch.block_index) == 32'(i);
      assign charge_hit = finish_go && found_r && 32'(best_idx_r) == 32'(i);
      assign ctrl.shift = shift;
      assign ctrl.wr    = load_hit || charge_hit;
      assign wr_data    = load_hit ? size_w : rem;

      wfba_cell #(.W(SIZE_WIDTH)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .shift_in (cell_val[NXT]),
        .wr_data  (wr_data),
        .val      (cell_val[i])
      );
    end
  endgenerate

  a_no_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("input transfer while a request is in progress");

  a_req_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.mode == MODE_REQ |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("request did not start a scan");

  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_FINISH) && found_r |-> best_val_r >= req_r)
    else $error("chosen block smaller than request");

  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_granted_r |-> out_block_r == '0 && out_rem_r == '0)
    else $error("refused result carries nonzero fields");

  a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && $past(state_r) == ST_SCAN |-> $past(last))
    else $error("scan ended early");

endmodule
`default_nettype wire

FILE: dv/worst_fit_block_allocator_top_tb.sv
`timescale 1ns / 1ps
module worst_fit_block_allocator_top_tb;
  import wfba_pkg::*;

  localparam int NBLK         = 16;
  localparam int DRAIN_CYCLES = 2 * (NBLK + 2);
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AT      = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic                   granted;
    logic [OUT_BLOCK_W-1:0] chosen_block;
    logic [OUT_SIZE_W-1:0]  remaining_size;
  } grant_t;

  localparam grant_t NO_GRANT = '0;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [IN_IDX_W-1:0]   idx;
    logic [IN_SIZE_W-1:0]  size;
    logic [CFG_W-1:0]      cfg_val;
    bit                    typed;
    grant_t                want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  wfba_in_if  in_if ();
  wfba_out_if out_if ();

  worst_fit_block_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block's table and register
  logic [IN_SIZE_W-1:0] free_sz [NBLK];
  logic [CFG_W-1:0]     blocks_cfg;
  grant_t               grants_due [$];

  int  fail_count    = 0;
  int  results_seen  = 0;
  int  cycles        = 0;
  bit  sink_steady   = 0;
  bit  send_steady   = 0;
  bit  long_hold_done = 0;

  dir_row_t dir_rows [24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, grants_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Worst fit: largest entry that holds the request, lowest index on a tie
  function automatic grant_t allocate(input logic [IN_SIZE_W-1:0] req);
    int     lim;
    int     best;
    bit     found;
    grant_t r;
    lim   = (blocks_cfg > NBLK) ? NBLK : int'(blocks_cfg);
    best  = 0;
    found = 0;
    r     = NO_GRANT;
    for (int j = 0; j < lim; j++) begin
      if (free_sz[j] >= req && (!found || free_sz[j] > free_sz[best])) begin
        best  = j;
        found = 1;
      end
    end
    if (found) begin
      free_sz[best]    = free_sz[best] - req;
      r.granted        = 1'b1;
      r.chosen_block   = best[OUT_BLOCK_W-1:0];
      r.remaining_size = free_sz[best];
    end
    return r;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_SIZE_W-1:0] req_size();
    int r;
    logic [IN_SIZE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) v = '0;
    else if (r < 18) v = '1;
    else if (r < 45) v = IN_SIZE_W'($urandom_range(1, 255));
    // aim at an existing entry, exact or one past it
    else if (r < 65) v = free_sz[$urandom_range(0, NBLK - 1)] + IN_SIZE_W'($urandom_range(0, 1));
    else v = IN_SIZE_W'($urandom);
    return v;
  endfunction

  function automatic logic [IN_SIZE_W-1:0] load_size();
    int r;
    logic [IN_SIZE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) v = '1;
    else if (r < 25) v = '0;
    else if (r < 55) v = IN_SIZE_W'($urandom_range(1, 4095));
    else v = IN_SIZE_W'($urandom);
    return v;
  endfunction

  task automatic push_item(input logic m, input logic [IN_IDX_W-1:0] ix,
                           input logic [IN_SIZE_W-1:0] sz, input bit typed, input grant_t want);
    int     gap;
    grant_t got;
    gap = pick_gap(send_steady);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid       = 1'b0;
      in_if.mode        = 1'($urandom);
      in_if.block_index = IN_IDX_W'($urandom);
      in_if.size        = IN_SIZE_W'($urandom);
    end
    @(negedge clk);
    in_if.valid       = 1'b1;
    in_if.mode        = m;
    in_if.block_index = ix;
    in_if.size        = sz;
    do @(posedge clk); while (!in_if.ready);
    if (m == MODE_LOAD) begin
      free_sz[ix] = sz;
    end else begin
      got = allocate(sz);
      grants_due.push_back(typed ? want : got);
    end
  endtask

  // Drop valid, wait for every result, then let a load in flight land
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    blocks_cfg = v;
  endtask

  task automatic flag(input string what, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got granted=%0d block=%0d remaining=%0d",
                 $time, out_if.granted, out_if.chosen_block, out_if.remaining_size);
        fail_count++;
      end else begin
        want = grants_due.pop_front();
        if (out_if.granted !== want.granted)
          flag("granted", want.granted, out_if.granted);
        if (out_if.chosen_block !== want.chosen_block)
          flag("chosen_block", want.chosen_block, out_if.chosen_block);
        if (out_if.remaining_size !== want.remaining_size)
          flag("remaining_size", want.remaining_size, out_if.remaining_size);
      end
    end
  end

  // Result side: random stalls, one long hold-off while the sender keeps going
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1;
        hold_left      = LONG_HOLD - 1;
        out_if.ready   = 1'b0;
      end else if (!sink_steady && $urandom_range(0, 9) == 0) begin
        hold_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  initial begin
    int phase_cfg [PHASES];
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_LOAD;
    in_if.block_index = '0;
    in_if.size        = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    foreach (free_sz[i]) free_sz[i] = '0;
    blocks_cfg = CFG_RESET;

    dir_rows = '{
      // empty table: a zero request still wins block 0, anything else is refused
      '{ROW_REQ,  4'd0,  16'h0000, 5'd0,  1'b1, '{1'b1, 4'd0, 16'd0}},
      '{ROW_REQ,  4'd5,  16'h0001, 5'd0,  1'b1, NO_GRANT},
      '{ROW_REQ,  4'hA,  16'hFFFF, 5'd0,  1'b1, NO_GRANT},
      '{ROW_LOAD, 4'd15, 16'hFFFF, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'hFFFF, 5'd0,  1'b1, '{1'b1, 4'd15, 16'd0}},
      '{ROW_LOAD, 4'd0,  16'hFFFF, 5'd0,  1'b0, NO_GRANT},
      '{ROW_LOAD, 4'd7,  16'h8000, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h0001, 5'd0,  1'b0, NO_GRANT},
      '{ROW_LOAD, 4'd15, 16'hFFFE, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h0010, 5'd0,  1'b0, NO_GRANT},
      '{ROW_LOAD, 4'd3,  16'h5555, 5'd0,  1'b0, NO_GRANT},
      '{ROW_LOAD, 4'd12, 16'hAAAA, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'hAAAA, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h0000, 5'd0,  1'b0, NO_GRANT},
      '{ROW_CFG,  4'd0,  16'h0000, 5'd0,  1'b0, NO_GRANT},
      // nothing scanned: even a zero request is refused
      '{ROW_REQ,  4'd0,  16'h0000, 5'd0,  1'b1, NO_GRANT},
      '{ROW_CFG,  4'd0,  16'h0000, 5'd1,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h0000, 5'd0,  1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'hFFFF, 5'd0,  1'b0, NO_GRANT},
      '{ROW_CFG,  4'd0,  16'h0000, 5'd31, 1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h0001, 5'd0,  1'b0, NO_GRANT},
      '{ROW_LOAD, 4'd8,  16'h0000, 5'd0,  1'b0, NO_GRANT},
      '{ROW_CFG,  4'd0,  16'h0000, 5'd16, 1'b0, NO_GRANT},
      '{ROW_REQ,  4'd0,  16'h7FFF, 5'd0,  1'b0, NO_GRANT}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:  write_blocks(dir_rows[i].cfg_val);
        ROW_LOAD: push_item(MODE_LOAD, dir_rows[i].idx, dir_rows[i].size, 1'b0, NO_GRANT);
        default:  push_item(MODE_REQ, dir_rows[i].idx, dir_rows[i].size,
                            dir_rows[i].typed, dir_rows[i].want);
      endcase
    end

    phase_cfg = '{$urandom_range(2, 15), 1, 0, 31, 16, $urandom_range(17, 30),
                  $urandom_range(1, 16), 16};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_blocks(CFG_W'(phase_cfg[ph]));
      send_steady = (ph == 2) || ($urandom_range(0, 3) == 0);
      sink_steady = (ph == 4) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 1) != 0)
          push_item(MODE_REQ, IN_IDX_W'($urandom), req_size(), 1'b0, NO_GRANT);
        else
          push_item(MODE_LOAD, IN_IDX_W'($urandom_range(0, NBLK - 1)), load_size(), 1'b0,
                    NO_GRANT);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/wfba_pkg.sv
hdl/wfba_if.sv
hdl/wfba_cell.sv
hdl/worst_fit_block_allocator_top.sv
dv/worst_fit_block_allocator_top_tb.sv
